// ===== design/lootc_pkg.sv =====
// Shared types and codes for the timed on/off light controller.
// No dependencies; lootc_exec and the controller unit import this package.
`timescale 1ns / 1ps

package lootc_pkg;

    localparam logic [2:0] CMD_OFF       = 3'd0;
    localparam logic [2:0] CMD_ON        = 3'd1;
    localparam logic [2:0] CMD_TOGGLE    = 3'd2;
    localparam logic [2:0] CMD_TIMED_OFF = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;
    localparam logic [2:0] CMD_OFF_EFFECT = 3'd5;
    localparam logic [2:0] CMD_RECALL    = 3'd6;
    localparam logic [2:0] CMD_STARTUP   = 3'd7;

    localparam logic [1:0] STAT_SUCCESS    = 2'd0;
    localparam logic [1:0] STAT_CONSTRAINT = 2'd1;
    localparam logic [1:0] STAT_UNSUP_CMD  = 2'd2;
    localparam logic [1:0] STAT_UNSUP_EP   = 2'd3;

    localparam logic [1:0] WANT_OFF    = 2'd0;
    localparam logic [1:0] WANT_ON     = 2'd1;
    localparam logic [1:0] WANT_TOGGLE = 2'd2;

    localparam logic [7:0] STARTUP_OFF    = 8'd0;
    localparam logic [7:0] STARTUP_ON     = 8'd1;
    localparam logic [7:0] STARTUP_TOGGLE = 8'd2;
    localparam logic [7:0] STARTUP_NULL   = 8'd255;

    localparam logic [7:0] EFFECT_DELAYED_OFF = 8'd0;
    localparam logic [7:0] EFFECT_DYING_LIGHT = 8'd1;
    localparam logic [7:0] DELAYED_OFF_VAR_MAX = 8'd2;

    localparam logic CFG_LIGHTING = 1'b0;
    localparam logic CFG_STARTUP  = 1'b1;

    typedef struct packed {
        logic        onoff;
        logic [15:0] ontime;
        logic [15:0] offwait;
        logic        scene;
        logic        timer;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        onoff:   1'b0,
        ontime:  16'd0,
        offwait: 16'd0,
        scene:   1'b1,
        timer:   1'b0
    };

    typedef struct packed {
        logic        lighting_enabled;
        logic [7:0]  startup_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        only_on;
        logic [15:0] on_req;
        logic [15:0] off_req;
        logic [7:0]  effect_id;
        logic [7:0]  effect_variant;
        logic        after_sw_update;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        fire;
        logic        fid;
        logic [7:0]  fvar;
    } rslt_t;

endpackage

// ===== design/lootc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lootc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/lootc_exec.sv =====
// Command execution for one endpoint entry: next entry values and result.
// Depends on lootc_pkg.
`timescale 1ns / 1ps

module lootc_exec
    import lootc_pkg::*;
#(
    parameter logic [15:0] TIME_NONE = 16'hFFFF
) (
    input  cfg_t   cfg,
    input  req_t   req,
    input  entry_t entry_in,
    output entry_t entry_out,
    output rslt_t  rslt
);

    function automatic entry_t set_light(entry_t e, logic [1:0] want, logic le);
        entry_t r;
        r = e;
        if (!((want == WANT_OFF && !e.onoff) || (want == WANT_ON && e.onoff)))
        begin
            if (!e.onoff)
            begin
                if (le)
                begin
                    if (e.ontime == 16'd0)
                    begin
                        r.offwait = 16'd0;
                        r.timer   = 1'b0;
                    end
                    r.scene = 1'b1;
                end
                r.onoff = 1'b1;
            end
            else
            begin
                r.onoff = 1'b0;
                if (le)
                begin
                    r.ontime = 16'd0;
                end
            end
        end
        return r;
    endfunction

    always_comb
    begin
        entry_t      e;
        logic [15:0] ot;
        logic [15:0] ow;
        logic [7:0]  evar;
        logic        v;
        logic        le;

        e    = entry_in;
        ot   = 16'd0;
        ow   = 16'd0;
        evar = req.effect_variant;
        v    = entry_in.onoff;
        le   = cfg.lighting_enabled;
        rslt = '0;

        unique case (req.cmd)
            CMD_OFF:    e = set_light(e, WANT_OFF, le);
            CMD_ON:     e = set_light(e, WANT_ON, le);
            CMD_TOGGLE: e = set_light(e, WANT_TOGGLE, le);
            CMD_TIMED_OFF:
            begin
                if (!le)
                begin
                    rslt.status = STAT_UNSUP_CMD;
                end
                else if (!(req.only_on && !e.onoff))
                begin
                    if (e.offwait != 16'd0 && !e.onoff)
                    begin
                        ow = (e.offwait < req.off_req) ? e.offwait : req.off_req;
                        e.offwait = ow;
                        ot = e.ontime;
                    end
                    else
                    begin
                        ot = (e.ontime > req.on_req) ? e.ontime : req.on_req;
                        e.ontime  = ot;
                        e.offwait = req.off_req;
                        e = set_light(e, WANT_ON, le);
                        ow = req.off_req;
                    end
                    if (ot < TIME_NONE && ow < TIME_NONE)
                    begin
                        e.timer = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                if (e.timer)
                begin
                    if (e.onoff)
                    begin
                        if (e.ontime != 16'd0)
                        begin
                            e.ontime = e.ontime - 16'd1;
                        end
                        if (e.ontime == 16'd0)
                        begin
                            e.offwait = 16'd0;
                            e = set_light(e, WANT_OFF, le);
                        end
                    end
                    else
                    begin
                        if (e.offwait != 16'd0)
                        begin
                            e.offwait = e.offwait - 16'd1;
                        end
                        if (e.offwait == 16'd0)
                        begin
                            e.timer = 1'b0;
                        end
                    end
                end
            end
            CMD_OFF_EFFECT:
            begin
                if (req.effect_id > EFFECT_DYING_LIGHT)
                begin
                    rslt.status = STAT_CONSTRAINT;
                end
                else if (!le)
                begin
                    rslt.status = STAT_UNSUP_CMD;
                end
                else
                begin
                    if (req.effect_id == EFFECT_DELAYED_OFF && evar > DELAYED_OFF_VAR_MAX)
                    begin
                        evar = 8'd0;
                    end
                    if (req.effect_id == EFFECT_DYING_LIGHT)
                    begin
                        evar = 8'd0;
                    end
                    e.scene = 1'b0;
                    if (e.onoff)
                    begin
                        rslt.fire = 1'b1;
                        rslt.fid  = req.effect_id[0];
                        rslt.fvar = evar;
                    end
                    e = set_light(e, WANT_OFF, le);
                end
            end
            CMD_RECALL:
            begin
                if (!le)
                begin
                    rslt.status = STAT_UNSUP_CMD;
                end
                else if (!e.scene)
                begin
                    e.scene = 1'b1;
                    e = set_light(e, WANT_ON, le);
                end
            end
            CMD_STARTUP:
            begin
                if (le)
                begin
                    if (cfg.startup_mode != STARTUP_NULL && !req.after_sw_update)
                    begin
                        if (cfg.startup_mode == STARTUP_OFF)
                        begin
                            v = 1'b0;
                        end
                        else if (cfg.startup_mode == STARTUP_ON)
                        begin
                            v = 1'b1;
                        end
                        else if (cfg.startup_mode == STARTUP_TOGGLE)
                        begin
                            v = ~v;
                        end
                    end
                    e = set_light(e, {1'b0, v}, le);
                end
            end
            default: e = entry_in;
        endcase

        entry_out = e;
    end

endmodule

// ===== design/light_on_off_timed_off_controller_unit.sv =====
// Timed on/off light controller: per-endpoint state, one result word per command.
// Handling of a command:
// - A command word enters on the s_ channel (s_tvalid/s_tready); tuser holds the
//   command code and tdata its arguments.
// - Each accepted word yields exactly one result word on the m_ channel: a status
//   and the endpoint's values after the command, plus the off-effect trigger.
// - The endpoint entries sit in a RAM with a registered read. A word is read at
//   acceptance, then updated and written back together with loading the result
//   register. Because of this read-modify-write of the entry RAM, the next word
//   is not accepted until the current one has been written back.
// - The next word is accepted while an earlier result still waits in the output
//   register. When the receiver stalls and the result register is full, the
//   update waits and s_tready stays low.
// - Configuration writes arrive on the cfg_ channel (index 0 lighting feature,
//   index 1 startup mode) and are always taken; write them only while idle.
// - Reset clears the control state and the per-endpoint valid bits; an entry
//   never written reads as off, zero times, scene flag set, timer stopped.
// Depends on lootc_pkg, lootc_ram and lootc_exec.
`timescale 1ns / 1ps

module light_on_off_timed_off_controller_unit
    import lootc_pkg::*;
#(
    parameter int NUM_ENDPOINTS = 8,
    parameter int TIME_NONE     = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // endpoint[7:0], accept_only_when_on[8], on_time_req[24:9], off_wait_req[40:25],
    // effect_id[48:41], effect_variant[56:49], after_sw_update[57], zero fill
    input  logic [63:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], light_on[2], on_time_now[18:3], off_wait_now[34:19],
    // scene_control_now[35], timer_active[36], effect_fire[37], effect_id_out[38],
    // effect_variant_out[46:39], zero fill
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int          ADDR_W  = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam logic [15:0] TN      = 16'(TIME_NONE);
    localparam logic [8:0]  EP_LIM  = 9'(NUM_ENDPOINTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    cfg_t                      cfg_reg;
    req_t                      req_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      ep_ok_reg;
    logic                      rd_valid_reg;
    logic [NUM_ENDPOINTS-1:0]  valid_reg;
    logic                      m_tvalid_reg;
    logic [47:0]               m_tdata_reg;

    logic                      accept;
    logic                      out_load;
    logic                      ram_we;
    logic [ADDR_W-1:0]         s_addr;
    logic [ENTRY_W-1:0]        ram_rdata;
    entry_t                    entry_cur;
    entry_t                    entry_new;
    rslt_t                     rslt;
    logic [47:0]               m_tdata_next;

    assign s_addr    = s_tdata[ADDR_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign ram_we    = out_load && ep_ok_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    lootc_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (NUM_ENDPOINTS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (entry_new),
        .re    (accept),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    assign entry_cur = rd_valid_reg ? entry_t'(ram_rdata) : ENTRY_RESET;

    lootc_exec #(
        .TIME_NONE (TN)
    ) u_exec (
        .cfg       (cfg_reg),
        .req       (req_reg),
        .entry_in  (entry_cur),
        .entry_out (entry_new),
        .rslt      (rslt)
    );

    always_comb
    begin
        if (ep_ok_reg)
        begin
            m_tdata_next = {1'b0, rslt.fvar, rslt.fid, rslt.fire, entry_new.timer,
                            entry_new.scene, entry_new.offwait, entry_new.ontime,
                            entry_new.onoff, rslt.status};
        end
        else
        begin
            m_tdata_next = {46'd0, STAT_UNSUP_EP};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            cfg_reg      <= '{lighting_enabled: 1'b1, startup_mode: STARTUP_NULL};
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LIGHTING: cfg_reg.lighting_enabled <= cfg_data[0];
                    CFG_STARTUP:  cfg_reg.startup_mode     <= cfg_data;
                    default:      cfg_reg                  <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= '{cmd:             s_tuser,
                              only_on:         s_tdata[8],
                              on_req:          s_tdata[24:9],
                              off_req:         s_tdata[40:25],
                              effect_id:       s_tdata[48:41],
                              effect_variant:  s_tdata[56:49],
                              after_sw_update: s_tdata[57]};
            addr_reg     <= s_addr;
            ep_ok_reg    <= ({1'b0, s_tdata[7:0]} < EP_LIM);
            rd_valid_reg <= valid_reg[s_addr];
        end
        if (out_load)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start an update");

    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("update finished without a result word");

    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (out_load && ep_ok_reg && state_reg == ST_EXEC))
        else $error("entry written outside an update");

    a_fire_success_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[37]) |-> (m_tdata[1:0] == STAT_SUCCESS && !m_tdata[2]))
        else $error("effect fired with the light on or a failed status");

endmodule

// ===== dv/light_state_checker.sv =====
// Scoreboard for the timed on/off light controller: watches the command, reply
// and register channels, keeps its own copy of every endpoint and compares replies.
// Depends on lootc_pkg for command, status and register codes.
`timescale 1ns / 1ps

module light_state_checker
    import lootc_pkg::*;
#(
    parameter int NUM_ENDPOINTS = 8,
    parameter int TIME_NONE     = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output int          fired
);

    localparam logic [15:0] NO_TIME = 16'(TIME_NONE);

    typedef struct packed {
        logic [1:0]  status;
        logic        light;
        logic [15:0] on_time;
        logic [15:0] off_wait;
        logic        scene;
        logic        timer;
        logic        fire;
        logic        fid;
        logic [7:0]  fvar;
    } reply_t;

    logic        lighting;
    logic [7:0]  startup;
    logic        lamp_on   [NUM_ENDPOINTS];
    logic [15:0] on_left   [NUM_ENDPOINTS];
    logic [15:0] wait_left [NUM_ENDPOINTS];
    logic        scene_ok  [NUM_ENDPOINTS];
    logic        ticking   [NUM_ENDPOINTS];

    reply_t predicted_replies[$];
    int     n_bad;
    int     n_checked;
    int     n_fired;

    function automatic void drive_lamp(int ep, logic [1:0] want);
        logic cur;
        cur = lamp_on[ep];
        if ((want == WANT_OFF && !cur) || (want == WANT_ON && cur))
            return;
        if (!cur)
        begin
            if (lighting)
            begin
                if (on_left[ep] == 16'd0)
                begin
                    wait_left[ep] = 16'd0;
                    ticking[ep]   = 1'b0;
                end
                scene_ok[ep] = 1'b1;
            end
            lamp_on[ep] = 1'b1;
        end
        else
        begin
            lamp_on[ep] = 1'b0;
            if (lighting)
                on_left[ep] = 16'd0;
        end
    endfunction

    function automatic reply_t apply_command(logic [2:0] cmd, logic [57:0] args);
        logic [7:0]  ep;
        logic        only_on;
        logic [15:0] on_req;
        logic [15:0] off_req;
        logic [15:0] ot;
        logic [15:0] ow;
        logic [7:0]  eid;
        logic [7:0]  evar;
        logic        swu;
        logic        v;
        int          i;
        reply_t      r;
        ep      = args[7:0];
        only_on = args[8];
        on_req  = args[24:9];
        off_req = args[40:25];
        eid     = args[48:41];
        evar    = args[56:49];
        swu     = args[57];
        r       = '0;
        i       = int'(ep);
        if (i >= NUM_ENDPOINTS)
        begin
            r.status = STAT_UNSUP_EP;
            return r;
        end
        case (cmd)
            CMD_OFF:    drive_lamp(i, WANT_OFF);
            CMD_ON:     drive_lamp(i, WANT_ON);
            CMD_TOGGLE: drive_lamp(i, WANT_TOGGLE);
            CMD_TIMED_OFF:
            begin
                if (!lighting)
                    r.status = STAT_UNSUP_CMD;
                else if (!(only_on && !lamp_on[i]))
                begin
                    if (wait_left[i] > 16'd0 && !lamp_on[i])
                    begin
                        ow = (wait_left[i] < off_req) ? wait_left[i] : off_req;
                        wait_left[i] = ow;
                        ot = on_left[i];
                    end
                    else
                    begin
                        ot = (on_left[i] > on_req) ? on_left[i] : on_req;
                        on_left[i]   = ot;
                        wait_left[i] = off_req;
                        drive_lamp(i, WANT_ON);
                        ow = off_req;
                    end
                    if (ot < NO_TIME && ow < NO_TIME)
                        ticking[i] = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (ticking[i])
                begin
                    if (lamp_on[i])
                    begin
                        if (on_left[i] > 16'd0)
                            on_left[i] = on_left[i] - 16'd1;
                        if (on_left[i] == 16'd0)
                        begin
                            wait_left[i] = 16'd0;
                            drive_lamp(i, WANT_OFF);
                        end
                    end
                    else
                    begin
                        if (wait_left[i] > 16'd0)
                            wait_left[i] = wait_left[i] - 16'd1;
                        if (wait_left[i] == 16'd0)
                            ticking[i] = 1'b0;
                    end
                end
            end
            CMD_OFF_EFFECT:
            begin
                if (eid > EFFECT_DYING_LIGHT)
                    r.status = STAT_CONSTRAINT;
                else if (!lighting)
                    r.status = STAT_UNSUP_CMD;
                else
                begin
                    if (eid == EFFECT_DELAYED_OFF && evar > DELAYED_OFF_VAR_MAX)
                        evar = 8'd0;
                    if (eid == EFFECT_DYING_LIGHT && evar != 8'd0)
                        evar = 8'd0;
                    scene_ok[i] = 1'b0;
                    if (lamp_on[i])
                    begin
                        r.fire = 1'b1;
                        r.fid  = eid[0];
                        r.fvar = evar;
                    end
                    drive_lamp(i, WANT_OFF);
                end
            end
            CMD_RECALL:
            begin
                if (!lighting)
                    r.status = STAT_UNSUP_CMD;
                else if (!scene_ok[i])
                begin
                    scene_ok[i] = 1'b1;
                    drive_lamp(i, WANT_ON);
                end
            end
            CMD_STARTUP:
            begin
                if (lighting)
                begin
                    v = lamp_on[i];
                    if (startup != STARTUP_NULL && !swu)
                    begin
                        if (startup == STARTUP_OFF)
                            v = 1'b0;
                        else if (startup == STARTUP_ON)
                            v = 1'b1;
                        else if (startup == STARTUP_TOGGLE)
                            v = !v;
                    end
                    drive_lamp(i, {1'b0, v});
                end
            end
            default: ;
        endcase
        r.light    = lamp_on[i];
        r.on_time  = on_left[i];
        r.off_wait = wait_left[i];
        r.scene    = scene_ok[i];
        r.timer    = ticking[i];
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            lighting = 1'b1;
            startup  = STARTUP_NULL;
            for (int e = 0; e < NUM_ENDPOINTS; e++)
            begin
                lamp_on[e]   = ENTRY_RESET.onoff;
                on_left[e]   = ENTRY_RESET.ontime;
                wait_left[e] = ENTRY_RESET.offwait;
                scene_ok[e]  = ENTRY_RESET.scene;
                ticking[e]   = ENTRY_RESET.timer;
            end
            predicted_replies.delete();
            n_bad     = 0;
            n_checked = 0;
            n_fired   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LIGHTING)
                    lighting = cfg_data[0];
                else
                    startup = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got.status   = m_tdata[1:0];
                got.light    = m_tdata[2];
                got.on_time  = m_tdata[18:3];
                got.off_wait = m_tdata[34:19];
                got.scene    = m_tdata[35];
                got.timer    = m_tdata[36];
                got.fire     = m_tdata[37];
                got.fid      = m_tdata[38];
                got.fvar     = m_tdata[46:39];
                if (predicted_replies.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: reply word %0h arrived with none expected", $time, m_tdata);
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("light_on", 16'(want.light), 16'(got.light));
                    check_field("on_time_now", want.on_time, got.on_time);
                    check_field("off_wait_now", want.off_wait, got.off_wait);
                    check_field("scene_control_now", 16'(want.scene), 16'(got.scene));
                    check_field("timer_active", 16'(want.timer), 16'(got.timer));
                    check_field("effect_fire", 16'(want.fire), 16'(got.fire));
                    check_field("effect_id_out", 16'(want.fid), 16'(got.fid));
                    check_field("effect_variant_out", 16'(want.fvar), 16'(got.fvar));
                    n_checked++;
                    if (want.fire)
                        n_fired++;
                end
            end
            if (s_tvalid && s_tready)
                predicted_replies.push_back(apply_command(s_tuser, s_tdata[57:0]));
        end
        mismatches  <= n_bad;
        outstanding <= predicted_replies.size();
        checked     <= n_checked;
        fired       <= n_fired;
    end

endmodule

// ===== dv/tb_light_on_off_timed_off_controller_unit.sv =====
// Testbench top for the timed on/off light controller: clock, reset, command
// stimulus, reply back-pressure and register writes, with the verdict at the end.
// Depends on lootc_pkg, the controller RTL and light_state_checker.
`timescale 1ns / 1ps

module tb_light_on_off_timed_off_controller_unit;
    import lootc_pkg::*;

    localparam int NUM_EP      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_WORDS = 120;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [47:0] m_tdata;
    wire         cfg_ready;

    int mismatches;
    int outstanding;
    int checked;
    int fired;
    int words_sent = 0;
    int settings   = 0;
    int cycles     = 0;
    bit hold_done  = 1'b0;

    always #5 clk = ~clk;

    light_on_off_timed_off_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    light_state_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .fired       (fired)
    );

    function automatic bit quiet();
        return words_sent >= 600 && words_sent < 760;
    endfunction

    function automatic logic [15:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(0, 10));
        else if (r < 70)
            return 16'd0;
        else if (r < 78)
            return 16'hFFFF;
        else if (r < 84)
            return 16'hFFFE;
        return 16'($urandom);
    endfunction

    task automatic issue(input logic [2:0] cmd, input logic [7:0] ep, input logic only_on,
                         input logic [15:0] on_t, input logic [15:0] off_t,
                         input logic [7:0] eid, input logic [7:0] evar, input logic swu);
        while (!quiet() && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, swu, evar, eid, off_t, on_t, only_on, ep};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic issue_plain(input logic [2:0] cmd, input logic [7:0] ep);
        issue(cmd, ep, 1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic lit, input logic [7:0] mode);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LIGHTING;
        cfg_data  <= {7'b0, lit};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_STARTUP;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic random_command(input logic [7:0] ep);
        logic [7:0] eid;
        logic [7:0] evar;
        eid  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        evar = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        issue(3'($urandom_range(0, 7)), ep, 1'($urandom), pick_time(), pick_time(),
              eid, evar, $urandom_range(0, 3) == 0);
    endtask

    task automatic random_scenario();
        int         r;
        int         n;
        logic [7:0] ep;
        r  = $urandom_range(0, 99);
        ep = 8'($urandom_range(0, NUM_EP - 1));
        if (r < 45)
        begin
            issue(CMD_TIMED_OFF, ep, $urandom_range(0, 3) == 0, pick_time(), pick_time(),
                  8'($urandom), 8'($urandom), 1'($urandom));
            n = $urandom_range(1, 30);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    random_command(ep);
                else
                    issue_plain(CMD_TICK, ep);
            end
        end
        else if (r < 85)
            random_command(ep);
        else if (r < 93)
            issue_plain(3'($urandom_range(0, 7)), 8'($urandom_range(NUM_EP, 255)));
        else
            issue(CMD_OFF_EFFECT, ep, 1'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom_range(2, 255)), 8'($urandom), 1'($urandom));
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d replies outstanding", cycles, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_sent >= 300)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= quiet() || $urandom_range(0, 99) >= 11;
        end
    end

    initial
    begin : stimulus
        logic       lit;
        logic [7:0] mode;
        int         target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: lighting on, startup mode null.
        issue_plain(CMD_ON, 0);
        issue_plain(CMD_OFF, 0);
        issue_plain(CMD_OFF, 0);
        issue_plain(CMD_TOGGLE, 0);
        issue_plain(CMD_TICK, 2);
        issue(CMD_TIMED_OFF, 1, 1'b1, 16'd5, 16'd5, 8'd0, 8'd0, 1'b0);
        issue(CMD_TIMED_OFF, 1, 1'b0, 16'd2, 16'd3, 8'd0, 8'd0, 1'b0);
        repeat (3) issue_plain(CMD_TICK, 1);
        issue(CMD_TIMED_OFF, 3, 1'b0, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 1'b0);
        issue(CMD_OFF_EFFECT, 1, 1'b0, 16'd0, 16'd0, 8'd2, 8'd0, 1'b0);
        issue(CMD_OFF_EFFECT, 3, 1'b0, 16'd0, 16'd0, EFFECT_DELAYED_OFF, 8'd7, 1'b0);
        issue_plain(CMD_RECALL, 3);
        issue_plain(CMD_RECALL, 3);
        issue(CMD_OFF_EFFECT, 3, 1'b0, 16'd0, 16'd0, EFFECT_DYING_LIGHT, 8'd1, 1'b0);
        issue(CMD_OFF_EFFECT, 4, 1'b0, 16'd0, 16'd0, EFFECT_DELAYED_OFF, 8'd2, 1'b0);
        issue(CMD_STARTUP, 5, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        issue_plain(CMD_OFF, 8);
        issue_plain(CMD_TICK, 255);
        issue(CMD_TIMED_OFF, 0, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        // Off with a pending off-wait, then a timed-off that shortens it.
        issue(CMD_TIMED_OFF, 6, 1'b0, 16'd4, 16'd9, 8'd0, 8'd0, 1'b0);
        issue_plain(CMD_OFF, 6);
        issue(CMD_TIMED_OFF, 6, 1'b0, 16'd1, 16'd3, 8'd0, 8'd0, 1'b0);
        repeat (3) issue_plain(CMD_TICK, 6);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       begin lit = 1'b1; mode = STARTUP_NULL;   end
                1:       begin lit = 1'b1; mode = STARTUP_OFF;    end
                2:       begin lit = 1'b1; mode = STARTUP_ON;     end
                3:       begin lit = 1'b0; mode = STARTUP_ON;     end
                4:       begin lit = 1'b1; mode = STARTUP_TOGGLE; end
                5:       begin lit = 1'b1; mode = 8'($urandom_range(3, 254)); end
                6:       begin lit = 1'b0; mode = STARTUP_NULL;   end
                default: begin lit = 1'b1; mode = STARTUP_TOGGLE; end
            endcase
            settle();
            configure(lit, mode);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_scenario();
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Run covered %0d command words under %0d register settings.",
                 words_sent, settings + 1);
        $display("%0d replies checked, %0d off-effect triggers, %0d mismatches.",
                 checked, fired, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lootc_pkg.sv
design/lootc_ram.sv
design/lootc_exec.sv
design/light_on_off_timed_off_controller_unit.sv
dv/light_state_checker.sv
dv/tb_light_on_off_timed_off_controller_unit.sv
